// ===== src/wpt_pkg.sv =====
// Shared types, codes and character-class helpers for the tokenizer.
package wpt_pkg;

  localparam int CharW   = 8;
  localparam int CfgW    = 64;
  localparam int CfgIdxW = 3;
  localparam int MaxRes  = 3;
  localparam int CntW    = 2;
  localparam int QDepth  = 2;
  localparam int QAw     = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SET_LO  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SET_MLO = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SET_MHI = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SET_HI  = 3'd4;

  // Held-character kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_PERIOD = 2'd2;
  localparam logic [1:0] KIND_PUNCT  = 2'd3;

  // Character classes
  localparam logic [1:0] CLS_WORD  = 2'd0;
  localparam logic [1:0] CLS_PUNCT = 2'd1;
  localparam logic [1:0] CLS_SPACE = 2'd2;

  localparam logic [CharW-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CharW-1:0] CH_PERIOD = 8'h2E;
  localparam logic [CharW-1:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             is_end;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             token_end;
    logic             string_done;
    logic             run_last;
  } out_word_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             tend;
  } res_ent_t;

  // All results caused by one input word
  typedef struct packed {
    res_ent_t [MaxRes-1:0] ent;
    logic [CntW-1:0]       cnt;
    logic                  done;
  } bundle_t;

  function automatic logic is_space_code(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_ascii_punct(input logic [CharW-1:0] c);
    if (c == CH_UNDER) return 1'b0;
    return ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
           ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
  endfunction

endpackage

// ===== src/wpt_front.sv =====
// Front end: config registers, classification, lookahead state, result bundling.
module wpt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wpt_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [wpt_pkg::CfgW-1:0]       cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wpt_pkg::in_word_t              in_data,
  input  logic                           q_full,
  output logic                           push,
  output wpt_pkg::bundle_t               push_bundle
);
  import wpt_pkg::*;

  logic                  mode_r;
  logic [4*CfgW-1:0]     set_r;
  logic [1:0]            held_kind_r, held_kind_nxt;
  logic [CharW-1:0]      held_char_r, held_char_nxt;
  logic [1:0]            cls;
  logic                  accept;
  logic [CharW-1:0]      c;
  logic                  c_space;

  assign c       = in_data.in_char;
  assign c_space = is_space_code(c);
  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // Write configuration registers; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      set_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:    mode_r <= cfg_wdata[0];
        CFG_SET_LO:  set_r[0*CfgW +: CfgW] <= cfg_wdata;
        CFG_SET_MLO: set_r[1*CfgW +: CfgW] <= cfg_wdata;
        CFG_SET_MHI: set_r[2*CfgW +: CfgW] <= cfg_wdata;
        CFG_SET_HI:  set_r[3*CfgW +: CfgW] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify the incoming character
  always_comb begin
    if (mode_r ? set_r[c] : is_ascii_punct(c)) cls = CLS_PUNCT;
    else if (c_space)                          cls = CLS_SPACE;
    else                                       cls = CLS_WORD;
  end

  // Build the result bundle: flush the held character, then the final one
  always_comb begin
    logic [CntW-1:0] n;
    res_ent_t [MaxRes-1:0] ent;
    n   = '0;
    ent = '0;
    case (held_kind_r)
      KIND_WORD: begin
        ent[n] = '{ch: held_char_r, tend: (cls != CLS_WORD)};
        n = n + 2'd1;
      end
      KIND_PERIOD: begin
        if (c_space) begin
          ent[n] = '{ch: CH_PERIOD, tend: 1'b0};
          n = n + 2'd1;
          ent[n] = '{ch: CH_SPACE, tend: 1'b1};
          n = n + 2'd1;
        end else begin
          ent[n] = '{ch: CH_PERIOD, tend: 1'b1};
          n = n + 2'd1;
        end
      end
      KIND_PUNCT: begin
        ent[n] = '{ch: held_char_r, tend: 1'b1};
        n = n + 2'd1;
      end
      default: ;
    endcase
    if (in_data.is_end) begin
      if (cls == CLS_WORD) begin
        ent[n] = '{ch: c, tend: 1'b1};
        n = n + 2'd1;
      end else if (cls == CLS_PUNCT) begin
        if (c == CH_PERIOD) begin
          ent[n] = '{ch: CH_PERIOD, tend: 1'b0};
          n = n + 2'd1;
          ent[n] = '{ch: CH_SPACE, tend: 1'b1};
          n = n + 2'd1;
        end else begin
          ent[n] = '{ch: c, tend: 1'b1};
          n = n + 2'd1;
        end
      end
    end
    push_bundle.ent  = ent;
    push_bundle.cnt  = n;
    push_bundle.done = in_data.is_end;
    push = accept && (n != '0);
  end

  // Advance lookahead state on each accepted word
  always_comb begin
    held_kind_nxt = held_kind_r;
    held_char_nxt = held_char_r;
    if (accept) begin
      held_kind_nxt = KIND_NONE;
      held_char_nxt = '0;
      if (!in_data.is_end) begin
        if (cls == CLS_WORD) begin
          held_kind_nxt = KIND_WORD;
          held_char_nxt = c;
        end else if (cls == CLS_PUNCT) begin
          held_kind_nxt = (c == CH_PERIOD) ? KIND_PERIOD : KIND_PUNCT;
          held_char_nxt = c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_kind_r <= KIND_NONE;
      held_char_r <= '0;
    end else begin
      held_kind_r <= held_kind_nxt;
      held_char_r <= held_char_nxt;
    end
  end

endmodule

// ===== src/wpt_queue.sv =====
// Short bundle queue between front end and back end.
module wpt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wpt_pkg::bundle_t push_bundle,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output wpt_pkg::bundle_t head
);
  import wpt_pkg::*;

  bundle_t          mem [QDepth];
  logic [QAw-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCntW'(QDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAw'(QDepth - 1)) ? '0 : wr_ptr_r + QAw'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAw'(QDepth - 1)) ? '0 : rd_ptr_r + QAw'(1);
    end
    if (push && !pop)      cnt_nxt = cnt_r + QCntW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store bundle payload
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_bundle;
  end

endmodule

// ===== src/wpt_back.sv =====
// Back end: serialize each bundle into result words, one per cycle while out_ready is high.
module wpt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  wpt_pkg::bundle_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output wpt_pkg::out_word_t out_data
);
  import wpt_pkg::*;

  logic [CntW-1:0] idx_r, idx_nxt;
  logic            last;

  assign last      = (idx_r == head.cnt - CntW'(1));
  assign out_valid = !empty;
  assign pop       = out_valid && out_ready && last;

  // Select current entry of the head bundle
  always_comb begin
    out_data.out_char    = head.ent[idx_r].ch;
    out_data.token_end   = head.ent[idx_r].tend;
    out_data.string_done = head.done && last;
    out_data.run_last    = last;
  end

  // Step through the bundle; restart on pop
  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) idx_nxt = last ? '0 : idx_r + CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

endmodule

// ===== src/word_punct_tokenizer_core.sv =====
// Top level of the streaming whitespace/punctuation tokenizer.
//
// Input channel (in_valid/in_ready/in_data) takes one character word per
// cycle while in_ready is high, with is_end on the string's final character.
// Output channel (out_valid/out_ready/out_data) returns token characters
// with token_end, string_done and run_last marks. The config port (cfg_we/
// cfg_index/cfg_wdata) selects the punctuation mode and loads the 256-bit
// set. The front end classifies each word and bundles its zero to three
// results, which wait in a two-entry queue; the back end sends one result
// per cycle while out_ready is high. Each bundle is registered in the queue
// before its first result is sent. Throughput is one input word per cycle
// while each word yields at most one result and out_ready stays high; a
// word yielding two or three results holds the back end until all are
// sent, the queue takes one more word while that burst drains, and in_ready
// then stays low until the burst's last result is accepted. A word that
// yields nothing passes with no output. Reset clears the config registers,
// the lookahead state and the queue. When the receiver stalls, out_data
// holds and the queue fills, then in_ready goes low until space frees up.
module word_punct_tokenizer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [wpt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wpt_pkg::CfgW-1:0]     cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wpt_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wpt_pkg::out_word_t           out_data
);
  import wpt_pkg::*;

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  bundle_t push_bundle;
  bundle_t head;

  wpt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  wpt_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (q_full),
    .pop         (pop),
    .empty       (q_empty),
    .head        (head)
  );

  wpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/tok_check_pkg.sv =====
// Scoreboard class: predicts the token stream and checks each result word.
package tok_check_pkg;
  import wpt_pkg::*;

  class tok_scoreboard;
    logic             mode;
    logic [255:0]     pset;
    logic [CharW-1:0] held_char;
    logic [1:0]       held_kind;
    out_word_t        expected_tokens[$];
    out_word_t        step_out[$];
    int               mismatches;
    int               checked;

    function new();
      mode       = 1'b0;
      pset       = '0;
      held_char  = '0;
      held_kind  = KIND_NONE;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Mirror a register write; indexes past the set registers do nothing
    function void note_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_MODE:    mode = val[0];
        CFG_SET_LO:  pset[63:0] = val;
        CFG_SET_MLO: pset[127:64] = val;
        CFG_SET_MHI: pset[191:128] = val;
        CFG_SET_HI:  pset[255:192] = val;
        default: ;
      endcase
    endfunction

    function bit space_code(logic [CharW-1:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function logic [1:0] char_class(logic [CharW-1:0] c);
      bit punct;
      if (mode)
        punct = pset[c];
      else
        punct = (c != CH_UNDER) &&
                ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                 (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126));
      if (punct) return CLS_PUNCT;
      return space_code(c) ? CLS_SPACE : CLS_WORD;
    endfunction

    function void emit(logic [CharW-1:0] ch, logic tend);
      out_word_t r;
      r.out_char    = ch;
      r.token_end   = tend;
      r.string_done = 1'b0;
      r.run_last    = 1'b0;
      step_out.push_back(r);
    endfunction

    // Predict the results of one accepted character word
    function void note_char(in_word_t w);
      logic [1:0] cls;
      int         n;
      cls = char_class(w.in_char);
      step_out.delete();
      // flush the held character now that its successor is known
      case (held_kind)
        KIND_WORD: emit(held_char, cls != CLS_WORD);
        KIND_PERIOD: begin
          if (space_code(w.in_char)) begin
            emit(CH_PERIOD, 1'b0);
            emit(CH_SPACE, 1'b1);
          end else begin
            emit(CH_PERIOD, 1'b1);
          end
        end
        KIND_PUNCT: emit(held_char, 1'b1);
        default: ;
      endcase
      held_kind = KIND_NONE;
      held_char = '0;
      if (w.is_end) begin
        if (cls == CLS_WORD) begin
          emit(w.in_char, 1'b1);
        end else if (cls == CLS_PUNCT) begin
          if (w.in_char == CH_PERIOD) begin
            emit(CH_PERIOD, 1'b0);
            emit(CH_SPACE, 1'b1);
          end else begin
            emit(w.in_char, 1'b1);
          end
        end
        n = step_out.size();
        if (n > 0) step_out[n-1].string_done = 1'b1;
      end else if (cls != CLS_SPACE) begin
        // hold back for lookahead
        held_char = w.in_char;
        if (cls == CLS_WORD)
          held_kind = KIND_WORD;
        else
          held_kind = (w.in_char == CH_PERIOD) ? KIND_PERIOD : KIND_PUNCT;
      end
      n = step_out.size();
      if (n > 0) step_out[n-1].run_last = 1'b1;
      foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    // Compare one accepted result word against the oldest prediction
    function void check_out(out_word_t got);
      out_word_t exp;
      checked++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got char %02h flags %b%b%b",
                 $time, got.out_char, got.token_end, got.string_done, got.run_last);
        return;
      end
      exp = expected_tokens.pop_front();
      if (got.out_char !== exp.out_char) begin
        mismatches++;
        $display("%0t: out_char expected %02h actual %02h",
                 $time, exp.out_char, got.out_char);
      end
      if (got.token_end !== exp.token_end) begin
        mismatches++;
        $display("%0t: token_end expected %b actual %b (char %02h)",
                 $time, exp.token_end, got.token_end, exp.out_char);
      end
      if (got.string_done !== exp.string_done) begin
        mismatches++;
        $display("%0t: string_done expected %b actual %b (char %02h)",
                 $time, exp.string_done, got.string_done, exp.out_char);
      end
      if (got.run_last !== exp.run_last) begin
        mismatches++;
        $display("%0t: run_last expected %b actual %b (char %02h)",
                 $time, exp.run_last, got.run_last, exp.out_char);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_word_punct_tokenizer_core.sv =====
// Top-level testbench for the whitespace/punctuation tokenizer core.
module tb_word_punct_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wpt_pkg::*;
  import tok_check_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 80;
  localparam int HoldAtWord  = 240;
  localparam int DrainCycles = 6;
  localparam int PhaseWords  = 58;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  in_word_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_word_t          out_data;

  tok_scoreboard sb = new();
  int  words_sent;
  int  strings_sent;
  int  settings_used;
  int  send_calm;
  int  recv_calm;
  int  cycles;
  bit  hold_req;

  word_punct_tokenizer_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle gap per word, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Bias characters toward letters, separators and punctuation
  function automatic logic [CharW-1:0] pick_char();
    int r;
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'(8'h61 + $urandom_range(0, 25));
      3: return 8'(8'h30 + $urandom_range(0, 9));
      4: begin
        r = $urandom_range(8, 13);
        return (r == 8) ? CH_SPACE : 8'(r);
      end
      5: return CH_PERIOD;
      6: return 8'($urandom_range(33, 47));
      7: return ($urandom_range(0, 1) == 0) ? CH_UNDER : 8'($urandom_range(123, 126));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one character word; return at the falling edge after acceptance
  task automatic send_char(input logic [CharW-1:0] c, input logic e);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data.in_char <= c;
    in_data.is_end  <= e;
    do @(posedge clk); while (!in_ready);
    sb.note_char(in_data);
    words_sent++;
    if (e) strings_sent++;
    if (words_sent == HoldAtWord) hold_req = 1'b1;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Drop valid, wait for every result, then let the pipeline empty out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.note_cfg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_set(input logic [CfgW-1:0] lo, input logic [CfgW-1:0] mlo,
                           input logic [CfgW-1:0] mhi, input logic [CfgW-1:0] hi);
    write_cfg(CFG_SET_LO, lo);
    write_cfg(CFG_SET_MLO, mlo);
    write_cfg(CFG_SET_MHI, mhi);
    write_cfg(CFG_SET_HI, hi);
    settings_used++;
  endtask

  // Random strings: mostly biased text, some long words, some raw bytes
  task automatic run_phase(input int budget);
    int target;
    int len;
    int flavor;
    target = words_sent + budget;
    while (words_sent < target) begin
      flavor = $urandom_range(0, 9);
      len = (flavor == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
        send_char((flavor == 1) ? 8'($urandom_range(0, 255)) : pick_char(), i == len - 1);
    end
    settle();
  endtask

  // Result side: random back-pressure plus one long hold-off
  initial begin : rx_proc
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldCycles;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_out(out_data);
      @(negedge clk);
    end
  end

  initial begin : main_proc
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    settings_used = 1;

    // Built-in classes straight out of reset
    send_str("a");
    send_str("ab.");
    send_str("x. y");
    send_str("..!");
    send_str(" ");
    send_str("a ");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b1);
    send_str("a_b\t.\n");
    settle();

    // Programmable set holding NUL, space and period
    write_set(64'h0000_4001_0000_0001, '0, '0, '0);
    write_cfg(CFG_MODE, 64'd1);
    send_char(CH_PERIOD, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h09, 1'b1);
    settle();

    // Built-in classes, mode written with all other bits set
    write_cfg(CFG_MODE, {{(CfgW-1){1'b1}}, 1'b0});
    settings_used++;
    run_phase(PhaseWords);

    // Every code is punctuation
    write_set('1, '1, '1, '1);
    write_cfg(CFG_MODE, '1);
    run_phase(PhaseWords);

    // Empty set: only whitespace separates
    write_set('0, '0, '0, '0);
    write_cfg(CFG_MODE, 64'd1);
    run_phase(PhaseWords);

    // Random set
    write_set({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    run_phase(PhaseWords);

    // Random low set with the period forced in
    write_set({$urandom, $urandom} | (64'd1 << CH_PERIOD), {$urandom, $urandom}, '0, '0);
    run_phase(PhaseWords);

    // Writes past the set registers must change nothing
    for (int k = 1; k <= 3; k++) write_cfg(CfgIdxW'(CFG_SET_HI + k), '1);
    write_cfg(CFG_MODE, '0);
    settings_used++;
    run_phase(PhaseWords);

    $display("Covered %0d characters in %0d strings over %0d punctuation settings",
             words_sent, strings_sent, settings_used);
    $display("Checked %0d token characters, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
